@@ hw/rtl/cqm_pkg.sv @@
// Shared constants and types for the circular queue with membership check.
// Used by cqm_cell and circular_queue_with_membership; depends on nothing.
package cqm_pkg;

    localparam int DEPTH_DEFAULT   = 8;
    localparam int ID_BITS_DEFAULT = 8;

    localparam int OP_BITS = 2;

    localparam logic [OP_BITS-1:0] OP_ENQ   = 2'd0;
    localparam logic [OP_BITS-1:0] OP_DEQ   = 2'd1;
    localparam logic [OP_BITS-1:0] OP_CHECK = 2'd2;
    localparam logic [OP_BITS-1:0] OP_NOP   = 2'd3;

    // Per-cell control: load takes the incoming identifier, shift takes the
    // value of the next cell up the ring.
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctrl;

endpackage

@@ hw/rtl/cqm_cell.sv @@
// One storage cell of the identifier ring.
// Depends on cqm_pkg for the cell control struct.
module cqm_cell #(
    parameter int ID_BITS = cqm_pkg::ID_BITS_DEFAULT
) (
    input  logic                i_clk,
    input  cqm_pkg::t_cell_ctrl i_ctrl,
    input  logic [ID_BITS-1:0]  i_id,
    input  logic [ID_BITS-1:0]  i_next,
    output logic [ID_BITS-1:0]  o_value
);

    logic [ID_BITS-1:0] r_value;
    logic [ID_BITS-1:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.load) begin
            n_value = i_id;
        end else if (i_ctrl.shift) begin
            n_value = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

@@ hw/rtl/circular_queue_with_membership.sv @@
// Top level: FIFO of identifiers held in a ring of cqm_cell instances,
// with a membership check that rotates the ring past cell 0.
// Depends on cqm_pkg and cqm_cell.
//
//  channel   | handshake         | fields
//  ----------+-------------------+---------------------------------------------
//  command   | start / busy      | i_operation, i_team_id
//  result    | o_valid (strobe)  | o_accepted, o_data_valid, o_dequeued_id,
//            |                   | o_absent, o_full_flag, o_empty_flag
//
// For enqueue, dequeue and the unused code the result strobes in the cycle
// after acceptance and busy stays low.
// Check holds busy while the ring makes one full turn, one entry compared
// at cell 0 per cycle; the result strobes in the cycle after the last comparison.
// Reset is synchronous and empties the queue; cell contents are not cleared.
// The receiver cannot stall: each result is present for exactly one cycle.
module circular_queue_with_membership #(
    parameter int DEPTH   = cqm_pkg::DEPTH_DEFAULT,
    parameter int ID_BITS = cqm_pkg::ID_BITS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [cqm_pkg::OP_BITS-1:0] i_operation,
    input  logic [ID_BITS-1:0]          i_team_id,
    output logic                        o_valid,
    output logic                        o_accepted,
    output logic                        o_data_valid,
    output logic [ID_BITS-1:0]          o_dequeued_id,
    output logic                        o_absent,
    output logic                        o_full_flag,
    output logic                        o_empty_flag
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = $clog2(DEPTH);

    logic [ID_BITS-1:0] w_value [DEPTH];
    logic [DEPTH-1:0]   w_load;
    logic               w_shift;
    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    logic               w_hit;
    logic               w_last;

    logic               r_busy,  n_busy;
    logic [CW-1:0]      r_count, n_count;
    logic [SW-1:0]      r_step,  n_step;
    logic [ID_BITS-1:0] r_id,    n_id;
    logic               r_found, n_found;
    logic               r_valid, n_valid;
    logic               r_acc,   n_acc;
    logic               r_dval,  n_dval;
    logic [ID_BITS-1:0] r_deq,   n_deq;
    logic               r_abs,   n_abs;
    logic               r_full,  n_full;
    logic               r_empty, n_empty;

    assign w_accept = start && !r_busy;
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_last   = (r_step == SW'(DEPTH - 1));
    // Position r_step of the walk holds a live entry only below the count.
    assign w_hit    = (CW'(r_step) < r_count) && (w_value[0] == r_id);

    assign w_shift = r_busy
                  || (w_accept && (i_operation == cqm_pkg::OP_DEQ) && !w_empty);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            cqm_pkg::t_cell_ctrl w_ctrl;

            assign w_load[g] = w_accept && (i_operation == cqm_pkg::OP_ENQ)
                            && !w_full && (r_count == CW'(g));
            assign w_ctrl.load  = w_load[g];
            assign w_ctrl.shift = w_shift;

            cqm_cell #(
                .ID_BITS(ID_BITS)
            ) u_cell (
                .i_clk  (i_clk),
                .i_ctrl (w_ctrl),
                .i_id   (i_team_id),
                .i_next (w_value[(g + 1) % DEPTH]),
                .o_value(w_value[g])
            );
        end
    endgenerate

    always_comb begin
        n_busy  = r_busy;
        n_count = r_count;
        n_step  = r_step;
        n_id    = r_id;
        n_found = r_found;
        n_valid = 1'b0;
        n_acc   = 1'b0;
        n_dval  = 1'b0;
        n_deq   = '0;
        n_abs   = 1'b0;
        n_full  = r_full;
        n_empty = r_empty;

        if (r_busy) begin
            if (w_hit) begin
                n_found = 1'b1;
            end
            n_step = r_step + SW'(1);
            if (w_last) begin
                n_busy  = 1'b0;
                n_valid = 1'b1;
                n_abs   = !(r_found || w_hit);
                n_full  = w_full;
                n_empty = w_empty;
            end
        end else if (w_accept) begin
            unique case (i_operation)
                cqm_pkg::OP_ENQ: begin
                    n_valid = 1'b1;
                    if (!w_full) begin
                        n_count = r_count + CW'(1);
                        n_acc   = 1'b1;
                    end
                end
                cqm_pkg::OP_DEQ: begin
                    n_valid = 1'b1;
                    if (!w_empty) begin
                        n_count = r_count - CW'(1);
                        n_dval  = 1'b1;
                        n_deq   = w_value[0];
                    end
                end
                cqm_pkg::OP_CHECK: begin
                    n_busy  = 1'b1;
                    n_step  = '0;
                    n_id    = i_team_id;
                    n_found = 1'b0;
                end
                default: begin
                    n_valid = 1'b1;
                end
            endcase
            if (i_operation != cqm_pkg::OP_CHECK) begin
                n_full  = (n_count == CW'(DEPTH));
                n_empty = (n_count == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
            r_step  <= '0;
            r_found <= 1'b0;
            r_valid <= 1'b0;
            r_full  <= 1'b0;
            r_empty <= 1'b1;
        end else begin
            r_busy  <= n_busy;
            r_count <= n_count;
            r_step  <= n_step;
            r_found <= n_found;
            r_valid <= n_valid;
            r_full  <= n_full;
            r_empty <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_acc  <= n_acc;
        r_dval <= n_dval;
        r_deq  <= n_deq;
        r_abs  <= n_abs;
    end

    assign busy          = r_busy;
    assign o_valid       = r_valid;
    assign o_accepted    = r_acc;
    assign o_data_valid  = r_dval;
    assign o_dequeued_id = r_deq;
    assign o_absent      = r_abs;
    assign o_full_flag   = r_full;
    assign o_empty_flag  = r_empty;

    // Every accepted item either reports at once or starts a ring walk.
    a_accept_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_valid || busy))
        else $error("accepted item produced neither a result nor a walk");

    // A result never appears while a walk is still running.
    a_no_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe during a busy walk");

    // Only a check command starts a walk.
    a_walk_from_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> ($past(start) && ($past(i_operation) == cqm_pkg::OP_CHECK)))
        else $error("walk started by something other than a check");

    // The occupancy never goes past the ring size, and full and empty exclude each other.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CW'(DEPTH)) && !(o_full_flag && o_empty_flag))
        else $error("occupancy out of range or conflicting flags");

endmodule

@@ dv/tb_circular_queue_with_membership.sv @@
// Self-checking testbench for circular_queue_with_membership: directed and random
// enqueue, dequeue, check and no-op commands, predicted in-line and compared per result.
// Depends on cqm_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_circular_queue_with_membership;

    localparam int DEPTH          = cqm_pkg::DEPTH_DEFAULT;
    localparam int ID_BITS        = cqm_pkg::ID_BITS_DEFAULT;
    localparam int OP_BITS        = cqm_pkg::OP_BITS;
    localparam int IDX_BITS       = $clog2(DEPTH);
    localparam int RANDOM_ITEMS   = 1150;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [OP_BITS-1:0] op;
        logic [ID_BITS-1:0] id;
        logic [7:0]         gap;
        logic               hold;
    } t_queue_cmd;

    typedef struct packed {
        logic               accepted;
        logic               data_valid;
        logic [ID_BITS-1:0] dequeued_id;
        logic               absent;
        logic               full_flag;
        logic               empty_flag;
    } t_queue_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic [OP_BITS-1:0] i_operation = cqm_pkg::OP_NOP;
    logic [ID_BITS-1:0] i_team_id = '0;
    logic               busy;
    logic               o_valid;
    logic               o_accepted;
    logic               o_data_valid;
    logic [ID_BITS-1:0] o_dequeued_id;
    logic               o_absent;
    logic               o_full_flag;
    logic               o_empty_flag;

    circular_queue_with_membership #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_team_id     (i_team_id),
        .o_valid       (o_valid),
        .o_accepted    (o_accepted),
        .o_data_valid  (o_data_valid),
        .o_dequeued_id (o_dequeued_id),
        .o_absent      (o_absent),
        .o_full_flag   (o_full_flag),
        .o_empty_flag  (o_empty_flag)
    );

    t_queue_cmd    pending_cmds[$];
    t_queue_result expected_results[$];

    // Shadow copy of the ring.
    logic [ID_BITS-1:0]  shadow_slots[DEPTH];
    logic [IDX_BITS-1:0] shadow_head;
    logic [IDX_BITS-1:0] shadow_tail;
    logic                shadow_empty;

    logic cmd_taken = 1'b0;
    int   gap_left = 0;
    int   idle_cycles = 0;
    int   error_count = 0;
    int   result_count = 0;
    int   cmd_count = 0;
    int   stored_count = 0;
    int   refused_count = 0;
    int   removed_count = 0;
    int   deq_empty_count = 0;
    int   check_count = 0;
    int   hit_count = 0;
    int   full_seen_count = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [IDX_BITS-1:0] ring_next(input logic [IDX_BITS-1:0] idx);
        return (idx == IDX_BITS'(DEPTH - 1)) ? '0 : idx + IDX_BITS'(1);
    endfunction

    function automatic t_queue_result predict_queue_op(
        input logic [OP_BITS-1:0] op,
        input logic [ID_BITS-1:0] id
    );
        t_queue_result       res;
        logic [IDX_BITS-1:0] idx;
        logic                scanning;
        res = '0;
        case (op)
            cqm_pkg::OP_ENQ: begin
                if (shadow_empty || shadow_head != shadow_tail) begin
                    shadow_slots[shadow_tail] = id;
                    shadow_tail  = ring_next(shadow_tail);
                    shadow_empty = 1'b0;
                    res.accepted = 1'b1;
                end
            end
            cqm_pkg::OP_DEQ: begin
                if (!shadow_empty) begin
                    res.dequeued_id = shadow_slots[shadow_head];
                    res.data_valid  = 1'b1;
                    shadow_head     = ring_next(shadow_head);
                    if (shadow_head == shadow_tail)
                        shadow_empty = 1'b1;
                end
            end
            cqm_pkg::OP_CHECK: begin
                // Walk the held entries from the oldest to the newest, stopping at the first match.
                res.absent = 1'b1;
                if (!shadow_empty) begin
                    idx      = shadow_head;
                    scanning = 1'b1;
                    for (int n = 0; n < DEPTH; n++) begin
                        if (scanning) begin
                            if (shadow_slots[idx] == id) begin
                                res.absent = 1'b0;
                                scanning   = 1'b0;
                            end
                            idx = ring_next(idx);
                            if (idx == shadow_tail)
                                scanning = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.full_flag  = !shadow_empty && shadow_head == shadow_tail;
        res.empty_flag = shadow_empty;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("result %0d: %s", result_count, msg);
        error_count++;
    endtask

    task automatic queue_cmd(input logic [OP_BITS-1:0] op, input logic [ID_BITS-1:0] id,
                             input int gap, input logic hold);
        t_queue_cmd c;
        c.op   = op;
        c.id   = id;
        c.gap  = 8'(gap);
        c.hold = hold;
        pending_cmds.push_back(c);
    endtask

    // Driver: a command stays on the ports until it is taken, then the next one
    // follows after its gap; a held command also waits until no result is outstanding.
    always @(negedge i_clk) begin : driver
        t_queue_cmd nxt;
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_operation <= cqm_pkg::OP_NOP;
            i_team_id   <= '0;
            gap_left = 0;
        end else if (!start || cmd_taken) begin
            if (gap_left != 0) begin
                start <= 1'b0;
                gap_left--;
            end else if (pending_cmds.size() != 0 &&
                         !(pending_cmds[0].hold && expected_results.size() != 0)) begin
                nxt = pending_cmds.pop_front();
                start       <= 1'b1;
                i_operation <= nxt.op;
                i_team_id   <= nxt.id;
                gap_left = nxt.gap;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks each strobed result, then predicts for a command taken
    // at this edge, and keeps the watchdog.
    always @(posedge i_clk) begin : monitor
        t_queue_result got;
        t_queue_result want;
        if (!i_rst_n) begin
            cmd_taken   = 1'b0;
            idle_cycles = 0;
        end else begin
            if (o_valid) begin
                got.accepted    = o_accepted;
                got.data_valid  = o_data_valid;
                got.dequeued_id = o_dequeued_id;
                got.absent      = o_absent;
                got.full_flag   = o_full_flag;
                got.empty_flag  = o_empty_flag;
                if (expected_results.size() == 0) begin
                    report_mismatch("result strobed with nothing outstanding");
                end else begin
                    want = expected_results.pop_front();
                    if (got.accepted !== want.accepted)
                        report_mismatch($sformatf("accepted %b, want %b",
                                                  got.accepted, want.accepted));
                    if (got.data_valid !== want.data_valid)
                        report_mismatch($sformatf("data_valid %b, want %b",
                                                  got.data_valid, want.data_valid));
                    if (got.dequeued_id !== want.dequeued_id)
                        report_mismatch($sformatf("dequeued_id %h, want %h",
                                                  got.dequeued_id, want.dequeued_id));
                    if (got.absent !== want.absent)
                        report_mismatch($sformatf("absent %b, want %b",
                                                  got.absent, want.absent));
                    if (got.full_flag !== want.full_flag)
                        report_mismatch($sformatf("full_flag %b, want %b",
                                                  got.full_flag, want.full_flag));
                    if (got.empty_flag !== want.empty_flag)
                        report_mismatch($sformatf("empty_flag %b, want %b",
                                                  got.empty_flag, want.empty_flag));
                end
                result_count++;
            end

            cmd_taken = start && !busy;
            if (cmd_taken) begin
                want = predict_queue_op(i_operation, i_team_id);
                expected_results.push_back(want);
                cmd_count++;
                if (i_operation == cqm_pkg::OP_ENQ) begin
                    if (want.accepted) stored_count++;
                    else refused_count++;
                end
                if (i_operation == cqm_pkg::OP_DEQ) begin
                    if (want.data_valid) removed_count++;
                    else deq_empty_count++;
                end
                if (i_operation == cqm_pkg::OP_CHECK) begin
                    check_count++;
                    if (!want.absent) hit_count++;
                end
                if (want.full_flag) full_seen_count++;
            end

            if (cmd_taken || o_valid) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no activity for %0d cycles", WATCHDOG_LIMIT);
                $display("tb_circular_queue_with_membership: errors");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int queued;
        int phase;
        int len;
        int enq_pct;
        int deq_pct;
        int chk_pct;
        int r;
        int gap;
        logic burst;
        logic [ID_BITS-1:0] id_base;
        logic [ID_BITS-1:0] id;
        logic [OP_BITS-1:0] op;

        for (int i = 0; i < DEPTH; i++)
            shadow_slots[i] = '0;
        shadow_head  = '0;
        shadow_tail  = '0;
        shadow_empty = 1'b1;

        // Empty queue: check, dequeue and the unused code.
        queue_cmd(cqm_pkg::OP_CHECK, 8'h00, 0, 1'b0);
        queue_cmd(cqm_pkg::OP_DEQ,   8'hFF, 0, 1'b0);
        queue_cmd(cqm_pkg::OP_NOP,   8'hFF, 1, 1'b0);
        // Leave a lone entry away from slot 0, then look it up.
        queue_cmd(cqm_pkg::OP_ENQ,   8'h00, 0, 1'b0);
        queue_cmd(cqm_pkg::OP_ENQ,   8'hFF, 0, 1'b0);
        queue_cmd(cqm_pkg::OP_ENQ,   8'h55, 2, 1'b0);
        queue_cmd(cqm_pkg::OP_ENQ,   8'hAA, 0, 1'b0);
        queue_cmd(cqm_pkg::OP_DEQ,   8'h00, 0, 1'b0);
        queue_cmd(cqm_pkg::OP_DEQ,   8'h00, 0, 1'b0);
        queue_cmd(cqm_pkg::OP_DEQ,   8'h00, 0, 1'b0);
        queue_cmd(cqm_pkg::OP_CHECK, 8'hAA, 0, 1'b0);
        queue_cmd(cqm_pkg::OP_CHECK, 8'h55, 0, 1'b0);
        // Fill up with wrap-around, refuse one more, then probe the full queue.
        for (int i = 1; i <= 7; i++)
            queue_cmd(cqm_pkg::OP_ENQ, ID_BITS'(i), 0, 1'b0);
        queue_cmd(cqm_pkg::OP_ENQ,   8'h80, 0, 1'b0);
        queue_cmd(cqm_pkg::OP_CHECK, 8'h07, 3, 1'b0);
        queue_cmd(cqm_pkg::OP_NOP,   8'h00, 0, 1'b0);
        queue_cmd(cqm_pkg::OP_DEQ,   8'h00, 0, 1'b0);

        queued = 0;
        phase  = 0;
        while (queued < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0: begin enq_pct = 60; deq_pct = 15; chk_pct = 20; end
                1: begin enq_pct = 20; deq_pct = 55; chk_pct = 20; end
                2: begin enq_pct = 35; deq_pct = 30; chk_pct = 30; end
                default: begin enq_pct = 30; deq_pct = 20; chk_pct = 45; end
            endcase
            len     = $urandom_range(20, 60);
            burst   = ($urandom_range(0, 4) == 0);
            id_base = ID_BITS'($urandom_range(0, 255)) & 8'hF0;
            for (int k = 0; k < len; k++) begin
                r = $urandom_range(0, 99);
                if (r < enq_pct) op = cqm_pkg::OP_ENQ;
                else if (r < enq_pct + deq_pct) op = cqm_pkg::OP_DEQ;
                else if (r < enq_pct + deq_pct + chk_pct) op = cqm_pkg::OP_CHECK;
                else op = cqm_pkg::OP_NOP;
                // A narrow pool per phase makes membership hits common.
                if ($urandom_range(0, 4) == 0) id = ID_BITS'($urandom_range(0, 255));
                else id = id_base | ID_BITS'($urandom_range(0, 15));
                r = $urandom_range(0, 99);
                if (burst || r < 55) gap = 0;
                else if (r < 90) gap = $urandom_range(1, 3);
                else gap = $urandom_range(8, 40);
                queue_cmd(op, id, gap, k == 0 && phase % 3 == 0);
                queued++;
            end
            phase++;
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DEPTH + 4) @(negedge i_clk);

        $display("%0d commands: %0d stored, %0d refused while full, %0d removed, %0d on empty",
                 cmd_count, stored_count, refused_count, removed_count, deq_empty_count);
        $display("%0d membership checks with %0d hits; full seen after %0d commands",
                 check_count, hit_count, full_seen_count);
        if (error_count == 0) begin
            $display("tb_circular_queue_with_membership: clean");
        end else begin
            $display("tb_circular_queue_with_membership: errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/cqm_pkg.sv
hw/rtl/cqm_cell.sv
hw/rtl/circular_queue_with_membership.sv
dv/tb_circular_queue_with_membership.sv
